// ----- hw/rtl/angle_unwrap_lowpass_smoother_top_defines.svh -----
// Assertion helpers for the angle smoother.
`ifndef ANGLE_UNWRAP_LOWPASS_SMOOTHER_TOP_DEFINES_SVH
`define ANGLE_UNWRAP_LOWPASS_SMOOTHER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AUL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AUL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/aul_pkg.sv -----
`timescale 1ns / 1ps

package aul_pkg;

  localparam int ANGLE_BITS = 32;
  localparam int GAIN_BITS = 16;
  localparam int TIME_BITS = 16;
  localparam int TIMER_BITS = 17;
  localparam int OP_BITS = 2;
  localparam int WIDE_BITS = ANGLE_BITS + 3;

  localparam int IN_DATA_BITS = ((ANGLE_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  typedef logic [OP_BITS-1:0] op_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic [GAIN_BITS:0] coef_t;

  localparam op_t OP_SAMPLE = OP_BITS'(0);
  localparam op_t OP_TICK = OP_BITS'(1);
  localparam op_t OP_CLEAR = OP_BITS'(2);

  localparam logic CFG_IDX_GAIN = 1'b0;
  localparam logic CFG_IDX_TIMEOUT = 1'b1;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'((64'd33554 << GAIN_BITS) >> 16);
  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(500);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  localparam wide_t FRAC_PI = WIDE_BITS'(205887);
  localparam wide_t FRAC_TWO_PI = WIDE_BITS'(411775);
  localparam angle_t ANGLE_MAX = {1'b0, {(ANGLE_BITS - 1){1'b1}}};
  localparam angle_t ANGLE_MIN = {1'b1, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic [ANGLE_BITS+GAIN_BITS:0] ROUND_HALF =
    (ANGLE_BITS + GAIN_BITS + 1)'(1) << (GAIN_BITS - 1);

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain;
    logic [TIME_BITS-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    angle_t angle;
    logic   holding;
  } result_t;

  function automatic angle_t sat_angle(input wide_t v);
    angle_t res;
    if (v > wide_t'(ANGLE_MAX)) begin
      res = ANGLE_MAX;
    end else if (v < wide_t'(ANGLE_MIN)) begin
      res = ANGLE_MIN;
    end else begin
      res = v[ANGLE_BITS-1:0];
    end
    return res;
  endfunction

  // Signed times unsigned Q1.16 coefficient, rounded to nearest with ties away from zero.
  function automatic wide_t scale_by(input angle_t x, input coef_t g);
    logic                          neg;
    logic [ANGLE_BITS-1:0]         mag;
    logic [ANGLE_BITS+GAIN_BITS:0] prod;
    logic [ANGLE_BITS:0]           rnd;
    wide_t                         mag_out;
    neg = x[ANGLE_BITS-1];
    mag = neg ? (~x + 1'b1) : x;
    prod = mag * g;
    rnd = (ANGLE_BITS + 1)'((prod + ROUND_HALF) >> GAIN_BITS);
    mag_out = wide_t'(rnd);
    return neg ? -mag_out : mag_out;
  endfunction

endpackage

// ----- hw/rtl/aul_cfg.sv -----
`timescale 1ns / 1ps

module aul_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aul_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [aul_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [aul_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output aul_pkg::cfg_t                       cfg
);
  import aul_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain <= GAIN_RESET;
      cfg.timeout <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        CFG_IDX_GAIN: cfg.gain <= pwdata[GAIN_BITS-1:0];
        CFG_IDX_TIMEOUT: cfg.timeout <= pwdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_GAIN: prdata = CFG_DATA_BITS'(cfg.gain);
      CFG_IDX_TIMEOUT: prdata = CFG_DATA_BITS'(cfg.timeout);
      default: prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/aul_core.sv -----
`timescale 1ns / 1ps

module aul_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  aul_pkg::op_t                   op,
  input  aul_pkg::angle_t                raw_angle,
  input  logic [aul_pkg::TIME_BITS-1:0]  elapsed_ms,
  input  aul_pkg::cfg_t                  cfg,
  output aul_pkg::result_t               result
);
  import aul_pkg::*;

  angle_t                filtered_value;
  angle_t                filtered_value_next;
  angle_t                previous_unwrapped;
  angle_t                previous_unwrapped_next;
  logic                  running;
  logic                  running_next;
  logic [TIMER_BITS-1:0] hold_timer;
  logic [TIMER_BITS-1:0] hold_timer_next;

  coef_t                 inv_gain;
  wide_t                 diff;
  wide_t                 unwrap_wide;
  angle_t                unwrapped;
  wide_t                 scaled_new;
  wide_t                 scaled_old;
  logic [TIMER_BITS:0]   timer_sum;
  logic [TIMER_BITS-1:0] timer_sat;
  logic                  holding;

  always_comb begin
    inv_gain = {1'b1, {GAIN_BITS{1'b0}}} - {1'b0, cfg.gain};
    diff = wide_t'(raw_angle) - wide_t'(previous_unwrapped);
    if (diff > FRAC_PI) begin
      unwrap_wide = wide_t'(raw_angle) - FRAC_TWO_PI;
    end else if (diff < -FRAC_PI) begin
      unwrap_wide = wide_t'(raw_angle) + FRAC_TWO_PI;
    end else begin
      unwrap_wide = wide_t'(raw_angle);
    end
    unwrapped = sat_angle(unwrap_wide);
    scaled_new = scale_by(unwrapped, {1'b0, cfg.gain});
    scaled_old = scale_by(filtered_value, inv_gain);
    timer_sum = {1'b0, hold_timer} + (TIMER_BITS + 1)'(elapsed_ms);
    timer_sat = timer_sum[TIMER_BITS] ? TIMER_MAX : timer_sum[TIMER_BITS-1:0];

    filtered_value_next = filtered_value;
    previous_unwrapped_next = previous_unwrapped;
    running_next = running;
    hold_timer_next = hold_timer;
    holding = 1'b0;

    unique case (op)
      OP_SAMPLE: begin
        if (!running) begin
          filtered_value_next = raw_angle;
          previous_unwrapped_next = raw_angle;
          running_next = 1'b1;
        end else begin
          previous_unwrapped_next = unwrapped;
          filtered_value_next = sat_angle(scaled_new + scaled_old);
          hold_timer_next = '0;
        end
      end
      OP_TICK: begin
        if (running) begin
          hold_timer_next = timer_sat;
          if (timer_sat > TIMER_BITS'(cfg.timeout)) begin
            holding = 1'b1;
          end else begin
            filtered_value_next = sat_angle(scaled_old);
          end
        end
      end
      OP_CLEAR: begin
        running_next = 1'b0;
        filtered_value_next = '0;
        hold_timer_next = '0;
      end
      default: ;
    endcase

    result.angle = filtered_value_next;
    result.holding = holding;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_value <= '0;
      previous_unwrapped <= '0;
      running <= 1'b0;
      hold_timer <= '0;
    end else if (fire) begin
      filtered_value <= filtered_value_next;
      previous_unwrapped <= previous_unwrapped_next;
      running <= running_next;
      hold_timer <= hold_timer_next;
    end
  end

endmodule

// ----- hw/rtl/angle_unwrap_lowpass_smoother_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Contents
// s_axis    in         tvalid / tready           op, raw_angle, elapsed_ms
// m_axis    out        tvalid / tready           smoothed_angle, holding
// apb       in         psel / penable / pready   smoothing_gain, hold_timeout
//
// Each request is held in the input register and is computed in one pass into the
// result register, so one request is taken per cycle while the output is not stalled.
// The filter state is updated in the same cycle that the result register loads.
// Reset clears the filter state and loads the default gain and timeout.
// A stalled result holds the input register; the input side stays ready while
// either register can move.
`include "angle_unwrap_lowpass_smoother_top_defines.svh"

module angle_unwrap_lowpass_smoother_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // raw_angle, elapsed_ms
  input  logic [aul_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // op
  input  logic [aul_pkg::OP_BITS-1:0]        s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // smoothed_angle
  output logic [aul_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // holding
  output logic                                m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aul_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [aul_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [aul_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import aul_pkg::*;

  cfg_t                 cfg;
  logic                 s1_valid;
  op_t                  s1_op;
  angle_t               s1_angle;
  logic [TIME_BITS-1:0] s1_elapsed;
  logic                 out_valid;
  result_t              out_result;
  result_t              core_result;
  logic                 advance;
  logic                 fire;
  logic [ANGLE_BITS-1:0] out_bits;

  assign advance = !out_valid || m_axis_tready;
  assign fire = s1_valid && advance;
  assign s_axis_tready = !s1_valid || advance;

  aul_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aul_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .op         (s1_op),
    .raw_angle  (s1_angle),
    .elapsed_ms (s1_elapsed),
    .cfg        (cfg),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op <= s_axis_tuser;
      s1_angle <= s_axis_tdata[ANGLE_BITS-1:0];
      s1_elapsed <= s_axis_tdata[ANGLE_BITS+TIME_BITS-1:ANGLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= core_result;
    end
  end

  assign out_bits = out_result.angle;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = OUT_DATA_BITS'(out_bits);
  assign m_axis_tuser = out_result.holding;

  `AUL_ASSERT_NEXT(a_clear_gives_zero, clk, rst, fire && (s1_op == OP_CLEAR), (out_result.angle == '0) && !out_result.holding, "clear request did not give a zero result")
  `AUL_ASSERT_NEXT(a_holding_on_tick_only, clk, rst, fire && (s1_op != OP_TICK), !out_result.holding, "holding flag set on a request that is not a tick")
  `AUL_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, s_axis_tready, "input not ready while the result register is empty")

endmodule

// ----- tb/smoother_checker.sv -----
`timescale 1ns / 1ps

module smoother_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [aul_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic [aul_pkg::OP_BITS-1:0]       s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [aul_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic                              m_axis_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aul_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [aul_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  logic                              pready,
  output int                                mismatches,
  output int                                pending
);
  import aul_pkg::*;

  result_t heading_q[$];
  longint heading_est;
  longint last_unwrapped;
  bit locked;
  int hold_ms;
  logic [GAIN_BITS-1:0] gain_q16;
  logic [TIME_BITS-1:0] timeout_ms;
  int result_idx;

  function automatic longint clamp_angle(input longint v);
    if (v > longint'(ANGLE_MAX)) begin
      return longint'(ANGLE_MAX);
    end else if (v < longint'(ANGLE_MIN)) begin
      return longint'(ANGLE_MIN);
    end
    return v;
  endfunction

  // Magnitude is scaled and rounded half away from zero, then the sign is restored.
  function automatic longint mul_gain(input longint x, input longint g);
    longint mag;
    longint r;
    mag = (x < 0) ? -x : x;
    r = (mag * g + (64'sd1 <<< (GAIN_BITS - 1))) >>> GAIN_BITS;
    return (x < 0) ? -r : r;
  endfunction

  function automatic result_t next_heading(input op_t op, input angle_t raw,
                                           input logic [TIME_BITS-1:0] ms);
    result_t res;
    longint g;
    longint inv;
    longint x;
    longint u;
    res.holding = 1'b0;
    g = longint'(gain_q16);
    inv = (64'sd1 <<< GAIN_BITS) - g;
    x = longint'(raw);
    case (op)
      OP_SAMPLE: begin
        if (!locked) begin
          heading_est = x;
          last_unwrapped = x;
          locked = 1'b1;
        end else begin
          u = x;
          if (x - last_unwrapped > longint'(FRAC_PI)) begin
            u = x - longint'(FRAC_TWO_PI);
          end else if (x - last_unwrapped < -longint'(FRAC_PI)) begin
            u = x + longint'(FRAC_TWO_PI);
          end
          u = clamp_angle(u);
          last_unwrapped = u;
          heading_est = clamp_angle(mul_gain(u, g) + mul_gain(heading_est, inv));
          hold_ms = 0;
        end
      end
      OP_TICK: begin
        if (locked) begin
          hold_ms = hold_ms + int'(ms);
          if (hold_ms > int'(TIMER_MAX)) begin
            hold_ms = int'(TIMER_MAX);
          end
          if (hold_ms > int'(timeout_ms)) begin
            res.holding = 1'b1;
          end else begin
            heading_est = clamp_angle(mul_gain(heading_est, inv));
          end
        end
      end
      OP_CLEAR: begin
        locked = 1'b0;
        heading_est = 0;
        hold_ms = 0;
      end
      default: begin
      end
    endcase
    res.angle = angle_t'(heading_est);
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      heading_q.delete();
      heading_est = 0;
      last_unwrapped = 0;
      locked = 1'b0;
      hold_ms = 0;
      gain_q16 = GAIN_RESET;
      timeout_ms = TIMEOUT_RESET;
      result_idx = 0;
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == CFG_IDX_GAIN) begin
          gain_q16 = pwdata[GAIN_BITS-1:0];
        end else begin
          timeout_ms = pwdata[TIME_BITS-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        heading_q.push_back(next_heading(s_axis_tuser, s_axis_tdata[ANGLE_BITS-1:0],
                                         s_axis_tdata[ANGLE_BITS +: TIME_BITS]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.angle = m_axis_tdata[ANGLE_BITS-1:0];
        got.holding = m_axis_tuser;
        if (heading_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("result %0d arrived with no request waiting: %0d holding %0b",
                     result_idx, got.angle, got.holding);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = heading_q.pop_front();
          if (want.angle !== got.angle || want.holding !== got.holding) begin
            if (mismatches < 10) begin
              $display("result %0d: smoothed_angle expected %0d got %0d,",
                       result_idx, want.angle, got.angle);
              $display("  holding expected %0b got %0b", want.holding, got.holding);
            end
            mismatches <= mismatches + 1;
          end
        end
        result_idx = result_idx + 1;
      end
    end
    pending <= heading_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import aul_pkg::*;

  localparam op_t OP_SPARE = OP_BITS'(3);
  localparam logic [CFG_ADDR_BITS-1:0] GAIN_ADDR = {CFG_IDX_GAIN, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] TIMEOUT_ADDR = {CFG_IDX_TIMEOUT, 2'b00};
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 320;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic [OP_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  int mismatches;
  int pending;
  bit calm = 1'b0;
  angle_t last_heading = '0;
  int quiet_cycles = 0;

  angle_unwrap_lowpass_smoother_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  smoother_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("angle_unwrap_lowpass_smoother_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(input op_t op, input angle_t ang, input logic [15:0] ms);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ms, ang};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned shape;
    angle_t ang;
    logic [15:0] ms;
    pick = $urandom_range(99);
    shape = $urandom_range(99);
    ang = angle_t'($urandom);
    ms = 16'($urandom);
    if (pick < 55) begin
      // Headings fall within one turn, drift from the last heading, jump at random or sit near the limits.
      if (shape < 40) begin
        ang = angle_t'(int'($urandom_range(411774)) - 205887);
      end else if (shape < 70) begin
        ang = last_heading + angle_t'(int'($urandom_range(40000)) - 20000);
      end else if (shape < 85) begin
        ang = angle_t'($urandom);
      end else if (shape < 93) begin
        ang = ANGLE_MAX - angle_t'($urandom_range(500000));
      end else begin
        ang = ANGLE_MIN + angle_t'($urandom_range(500000));
      end
      last_heading = ang;
      push_request(OP_SAMPLE, ang, ms);
    end else if (pick < 88) begin
      if (shape < 70) begin
        ms = 16'($urandom_range(120));
      end else if (shape < 90) begin
        ms = 16'($urandom_range(1000));
      end
      push_request(OP_TICK, ang, ms);
    end else if (pick < 94) begin
      push_request(OP_CLEAR, ang, ms);
    end else begin
      push_request(OP_SPARE, ang, ms);
    end
  endtask

  initial begin
    logic [15:0] gains[5];
    logic [15:0] timeouts[5];
    gains = '{16'd0, 16'hFFFF, 16'd1, 16'd33554, 16'($urandom)};
    timeouts = '{16'd0, 16'hFFFF, 16'd37, 16'd500, 16'($urandom_range(2000))};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset gain and timeout.
    push_request(OP_TICK, angle_t'($urandom), 16'hFFFF);
    push_request(OP_SPARE, angle_t'($urandom), 16'($urandom));
    push_request(OP_CLEAR, angle_t'($urandom), 16'($urandom));
    push_request(OP_SAMPLE, ANGLE_MAX, 16'hFFFF);
    push_request(OP_SAMPLE, ANGLE_MAX, 16'h0000);
    push_request(OP_SAMPLE, ANGLE_MAX - 300000, 16'($urandom));
    push_request(OP_SAMPLE, ANGLE_MIN, 16'($urandom));
    push_request(OP_SAMPLE, '0, 16'($urandom));
    push_request(OP_SAMPLE, angle_t'(205887), 16'($urandom));
    push_request(OP_TICK, ANGLE_MIN, 16'd0);
    push_request(OP_TICK, ANGLE_MAX, 16'd499);
    push_request(OP_TICK, angle_t'($urandom), 16'd1);
    push_request(OP_TICK, angle_t'($urandom), 16'd1);
    push_request(OP_TICK, angle_t'($urandom), 16'hFFFF);
    push_request(OP_TICK, angle_t'($urandom), 16'hFFFF);
    push_request(OP_TICK, angle_t'($urandom), 16'hFFFF);
    push_request(OP_SPARE, angle_t'($urandom), 16'($urandom));
    push_request(OP_SAMPLE, angle_t'(-205888), 16'($urandom));
    push_request(OP_TICK, angle_t'($urandom), 16'd5);
    push_request(OP_CLEAR, angle_t'($urandom), 16'($urandom));
    push_request(OP_SAMPLE, ANGLE_MIN, 16'($urandom));
    push_request(OP_SAMPLE, ANGLE_MIN, 16'($urandom));
    push_request(OP_SAMPLE, ANGLE_MIN + 300000, 16'($urandom));
    push_request(OP_CLEAR, angle_t'($urandom), 16'($urandom));

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      write_reg(GAIN_ADDR, CFG_DATA_BITS'(gains[phase]));
      write_reg(TIMEOUT_ADDR, CFG_DATA_BITS'(timeouts[phase]));
      calm = (phase == 2);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_request();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("angle_unwrap_lowpass_smoother_top test passed");
    end else begin
      $display("angle_unwrap_lowpass_smoother_top test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/aul_pkg.sv
hw/rtl/aul_cfg.sv
hw/rtl/aul_core.sv
hw/rtl/angle_unwrap_lowpass_smoother_top.sv
tb/smoother_checker.sv
tb/tb.sv
